>>> rtl/pru_pkg.sv
// shared types, constants and pixel arithmetic for the png rgba unfilter
`timescale 1ns / 1ps
`default_nettype none
package pru_pkg;

  localparam int MAX_WIDTH = 1024;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_OUTPUT_FORMAT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef enum logic {
    FMT_BGRA8888 = 1'b0,
    FMT_ARGB4444 = 1'b1
  } format_t;

  typedef struct packed {
    logic [7:0] filter_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        end_of_row;
    logic        end_of_image;
  } out_item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    pa = da[10] ? 11'(-da) : 11'(da);
    pb = db[10] ? 11'(-db) : 11'(db);
    pc = dc[10] ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

  function automatic logic [7:0] predict(input filter_t f, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    unique case (f)
      FILT_SUB:   return a;
      FILT_UP:    return b;
      FILT_AVG:   return sum[8:1];
      FILT_PAETH: return paeth(a, b, c);
      default:    return 8'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/pru_if.sv
// stream interfaces for filtered input pixels and reconstructed output pixels
`timescale 1ns / 1ps
`default_nettype none
interface pru_in_if;
  logic              valid;
  logic              ready;
  pru_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pru_out_if;
  logic               valid;
  logic               ready;
  pru_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pru_ram.sv
// generic single-clock ram, one write and one read port, registered read
`timescale 1ns / 1ps
`default_nettype none
module pru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/png_rgba_unfilter.sv
// png scanline unfilter for 8-bit rgba with line buffer and bgra/argb4444 output
// path: an accepted item passes the stage 1 register, then the output register
// throughput: one pixel per cycle unless the output stalls, set by the line buffer
//   read and the combinational left-pixel add/predict loop
// reset: counters, filter and handshake state clear, registers return to
//   width 1, height 1, bgra8888; the line buffer is not cleared and needs no pass
`timescale 1ns / 1ps
`default_nettype none
module png_rgba_unfilter #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [pru_pkg::CFG_W-1:0]      wr_data,
  pru_in_if.sink                              filtered,
  pru_out_if.source                           pixels
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > pru_pkg::WIDTH_W) ? CW + 1 : pru_pkg::WIDTH_W;
  localparam int HW = pru_pkg::HEIGHT_W;

  // configuration
  logic [pru_pkg::WIDTH_W-1:0] image_width;
  logic [HW-1:0]               image_height;
  pru_pkg::format_t            output_format;

  // position state
  logic [CW-1:0]    column_count;
  logic [HW-1:0]    row_count;
  pru_pkg::filter_t current_filter;

  // stage 1 (line buffer read returns)
  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic             s1_first_col;
  logic             s1_top_row;
  pru_pkg::filter_t s1_filter;
  logic [31:0]      s1_raw;
  logic             s1_eor;
  logic             s1_eoi;

  // neighbours and last line buffer write for forwarding
  logic [31:0]   left_pixel;
  logic [31:0]   upper_left_pixel;
  logic          wr_seen;
  logic [CW-1:0] wr_col;
  logic [31:0]   wr_pixel;

  // output register
  logic               out_valid;
  pru_pkg::out_item_t out_item;

  logic             accept;
  logic             s1_adv;
  logic             s1_write;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [WW-1:0]    col_inc;
  logic [HW:0]      row_inc;
  logic             eor;
  logic             eoi;
  pru_pkg::filter_t ft_code;
  pru_pkg::filter_t eff_filter;
  logic [31:0]      ram_rdata;
  logic [31:0]      up_raw;
  logic [31:0]      left;
  logic [31:0]      up;
  logic [31:0]      upper_left;
  logic [31:0]      px;
  logic [31:0]      res;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= pru_pkg::WIDTH_W'(1);
      image_height  <= HW'(1);
      output_format <= pru_pkg::FMT_BGRA8888;
    end else if (wr_en) begin
      unique case (wr_index)
        pru_pkg::REG_IMAGE_WIDTH:   image_width   <= wr_data[pru_pkg::WIDTH_W-1:0];
        pru_pkg::REG_IMAGE_HEIGHT:  image_height  <= wr_data[HW-1:0];
        pru_pkg::REG_OUTPUT_FORMAT: output_format <= pru_pkg::format_t'(wr_data[0]);
        default: ;
      endcase
    end
  end

  assign s1_adv          = !out_valid || pixels.ready;
  assign filtered.ready  = !s1_valid || s1_adv;
  assign accept          = filtered.valid && filtered.ready;
  assign s1_write        = s1_valid && s1_adv;

  // effective bounds: zero counts as one, width saturates at the buffer depth
  always_comb begin
    w_eff = WW'(image_width);
    if (w_eff == '0) begin
      w_eff = WW'(1);
    end else if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = (image_height == '0) ? HW'(1) : image_height;
  end

  assign col_inc = WW'(column_count) + WW'(1);
  assign row_inc = {1'b0, row_count} + (HW + 1)'(1);
  assign eor     = col_inc >= w_eff;
  assign eoi     = eor && (row_inc >= {1'b0, h_eff});

  // unknown filter types act as none
  assign ft_code = (filtered.data.filter_type <= 8'(pru_pkg::FILT_PAETH))
                 ? pru_pkg::filter_t'(filtered.data.filter_type[2:0])
                 : pru_pkg::FILT_NONE;
  assign eff_filter = (column_count == '0) ? ft_code : current_filter;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      current_filter <= pru_pkg::FILT_NONE;
    end else if (accept) begin
      current_filter <= eff_filter;
      if (eor) begin
        column_count <= '0;
        row_count    <= eoi ? '0 : row_inc[HW-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col       <= column_count;
      s1_first_col <= column_count == '0;
      s1_top_row   <= row_count == '0;
      s1_filter    <= eff_filter;
      s1_raw       <= {filtered.data.alpha_in, filtered.data.blue_in,
                       filtered.data.green_in, filtered.data.red_in};
      s1_eor       <= eor;
      s1_eoi       <= eoi;
    end
  end

  pru_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_col),
    .wdata (px),
    .re    (accept),
    .raddr (column_count),
    .rdata (ram_rdata)
  );

  // the last write holds the current content of its entry, so it can always stand in
  assign up_raw     = (wr_seen && wr_col == s1_col) ? wr_pixel : ram_rdata;
  assign left       = s1_first_col ? '0 : left_pixel;
  assign up         = s1_top_row ? '0 : up_raw;
  assign upper_left = (s1_first_col || s1_top_row) ? '0 : upper_left_pixel;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[8*i +: 8] = s1_raw[8*i +: 8]
                   + pru_pkg::predict(s1_filter, left[8*i +: 8], up[8*i +: 8],
                                      upper_left[8*i +: 8]);
    end
  end

  // px holds r in the low byte, then g, b, a
  always_comb begin
    unique case (output_format)
      pru_pkg::FMT_ARGB4444: res = {16'd0, px[31:28], px[7:4], px[15:12], px[23:20]};
      default:               res = {px[31:24], px[7:0], px[15:8], px[23:16]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_seen <= 1'b0;
    end else if (s1_write) begin
      wr_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      left_pixel       <= px;
      upper_left_pixel <= up_raw;
      wr_col           <= s1_col;
      wr_pixel         <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      out_item.pixel_out    <= res;
      out_item.end_of_row   <= s1_eor;
      out_item.end_of_image <= s1_eoi;
    end
  end

  assign pixels.valid = out_valid;
  assign pixels.data  = out_item;

endmodule
`default_nettype wire
